FILE: hw/rtl/bpa_pkg.sv
// Shared types and constants for the buddy page allocator.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package bpa_pkg;

    localparam int MAX_ORDER  = 9;
    localparam int NUM_ORDERS = MAX_ORDER + 1;
    localparam int NUM_PAGES  = 1 << MAX_ORDER;
    localparam int ADDR_W     = MAX_ORDER;
    localparam int CNT_W      = MAX_ORDER + 1;
    localparam int ORD_W      = 4;
    localparam int LVL_W      = $clog2(NUM_ORDERS);

    // Action codes of an input transaction.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Status codes of a result transaction.
    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ORD_W-1:0] block_order;
        logic [8:0]       page_address;
    } bpa_req_t;

    typedef struct packed {
        logic       status;
        logic [8:0] granted_address;
    } bpa_rsp_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } bpa_hs_t;

endpackage

FILE: hw/rtl/bpa_link_ram.sv
// Next-link store of the free lists: one entry per page.
// One write port and one read port with registered read data; uses bpa_pkg.
`timescale 1ns / 1ps

module bpa_link_ram (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [bpa_pkg::ADDR_W-1:0] waddr,
    input  logic [bpa_pkg::ADDR_W-1:0] wdata,
    input  logic [bpa_pkg::ADDR_W-1:0] raddr,
    output logic [bpa_pkg::ADDR_W-1:0] rdata
);
    import bpa_pkg::*;

    logic [ADDR_W-1:0] mem [NUM_PAGES];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/bpa_seq.sv
// Sequencer of the allocator: list heads, tails and counts, and the walks
// over the linked free lists. Uses bpa_pkg and bpa_link_ram.
`timescale 1ns / 1ps

module bpa_seq (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  bpa_pkg::bpa_req_t req,
    output bpa_pkg::bpa_hs_t  rsp_hs_out,
    input  logic              rsp_ready,
    output bpa_pkg::bpa_rsp_t rsp
);
    import bpa_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_SCAN      = 15'b000000000000010,
        S_TAKE      = 15'b000000000000100,
        S_SPLIT     = 15'b000000000001000,
        S_FREE_APP  = 15'b000000000010000,
        S_HOLD_INIT = 15'b000000000100000,
        S_HOLD_CHK  = 15'b000000001000000,
        S_HOLD_RD   = 15'b000000010000000,
        S_MERGE     = 15'b000000100000000,
        S_UNL_START = 15'b000001000000000,
        S_UNL_TAKE  = 15'b000010000000000,
        S_UNL_RD    = 15'b000100000000000,
        S_UNL_FIX   = 15'b001000000000000,
        S_UNL_NEXT  = 15'b010000000000000,
        S_DONE      = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] head_reg  [NUM_ORDERS];
    logic [ADDR_W-1:0] head_next [NUM_ORDERS];
    logic [ADDR_W-1:0] tail_reg  [NUM_ORDERS];
    logic [ADDR_W-1:0] tail_next [NUM_ORDERS];
    logic [CNT_W-1:0]  count_reg [NUM_ORDERS];
    logic [CNT_W-1:0]  count_next[NUM_ORDERS];

    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [LVL_W-1:0]  src_reg, src_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic              tgt_sel_reg, tgt_sel_next;
    logic              status_reg, status_next;
    logic [ADDR_W-1:0] granted_reg, granted_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_wdata, rd_addr, rd_data;

    logic              app_en;
    logic [LVL_W-1:0]  app_ord;
    logic [ADDR_W-1:0] app_val;

    logic [ADDR_W-1:0] bit_lvl, buddy, merged, tgt, half;
    logic [LVL_W-1:0]  src_dn;
    logic [CNT_W-1:0]  cnt;

    bpa_link_ram u_link (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Buddy arithmetic for the current merge level and split halves.
    always_comb begin
        bit_lvl = ADDR_W'(1) << lvl_reg;
        buddy   = addr_reg ^ bit_lvl;
        merged  = addr_reg & ~bit_lvl;
        tgt     = tgt_sel_reg ? addr_reg : buddy;
        cnt     = count_reg[lvl_reg];
        src_dn  = src_reg - 1'b1;
        half    = blk_reg + (ADDR_W'(1) << src_dn);
    end

    // Sequencer next-state logic.
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        lvl_next     = lvl_reg;
        src_next     = src_reg;
        addr_next    = addr_reg;
        blk_next     = blk_reg;
        cur_next     = cur_reg;
        pos_next     = pos_reg;
        tgt_sel_next = tgt_sel_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        rd_addr      = '0;
        app_en       = 1'b0;
        app_ord      = '0;
        app_val      = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    lvl_next     = LVL_W'(req.block_order);
                    src_next     = LVL_W'(req.block_order);
                    addr_next    = req.page_address;
                    granted_next = '0;
                    if (req.block_order > ORD_W'(MAX_ORDER)) begin
                        status_next = ST_FAIL;
                        state_next  = S_DONE;
                    end else if (req.action == ACT_ALLOC) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FREE_APP;
                    end
                end
            end

            // Look for the nearest nonempty list at or above the order.
            S_SCAN: begin
                if (count_reg[src_reg] != '0) begin
                    blk_next   = head_reg[src_reg];
                    rd_addr    = head_reg[src_reg];
                    state_next = S_TAKE;
                end else if (src_reg == LVL_W'(MAX_ORDER)) begin
                    status_next = ST_FAIL;
                    state_next  = S_DONE;
                end else begin
                    src_next = src_reg + 1'b1;
                end
            end

            // Take the head of the source list.
            S_TAKE: begin
                if (count_reg[src_reg] > CNT_W'(1)) begin
                    head_next[src_reg] = rd_data;
                end
                count_next[src_reg] = count_reg[src_reg] - 1'b1;
                state_next          = S_SPLIT;
            end

            // Split one order down; the lower list is empty here.
            S_SPLIT: begin
                if (src_reg == lvl_reg) begin
                    status_next  = ST_OK;
                    granted_next = blk_reg;
                    state_next   = S_DONE;
                end else begin
                    head_next[src_dn]  = half;
                    tail_next[src_dn]  = half;
                    count_next[src_dn] = CNT_W'(1);
                    mem_we             = 1'b1;
                    mem_waddr          = blk_reg;
                    mem_wdata          = half;
                    src_next           = src_dn;
                end
            end

            S_FREE_APP: begin
                app_en  = 1'b1;
                app_ord = lvl_reg;
                app_val = addr_reg;
                if (lvl_reg == LVL_W'(MAX_ORDER)) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_HOLD_INIT;
                end
            end

            // Search the list of this level for the buddy.
            S_HOLD_INIT: begin
                cur_next   = head_reg[lvl_reg];
                pos_next   = '0;
                state_next = S_HOLD_CHK;
            end

            S_HOLD_CHK: begin
                if (pos_reg >= cnt) begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end else if (cur_reg == buddy) begin
                    state_next = S_MERGE;
                end else if ((pos_reg + 1'b1) < cnt) begin
                    rd_addr    = cur_reg;
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_HOLD_RD;
                end else begin
                    status_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_HOLD_RD: begin
                cur_next   = rd_data;
                state_next = S_HOLD_CHK;
            end

            S_MERGE: begin
                app_en       = 1'b1;
                app_ord      = lvl_reg + 1'b1;
                app_val      = merged;
                tgt_sel_next = 1'b0;
                state_next   = S_UNL_START;
            end

            // Remove the first occurrence of the target from the list.
            S_UNL_START: begin
                if (cnt == '0) begin
                    state_next = S_UNL_NEXT;
                end else if (head_reg[lvl_reg] == tgt) begin
                    if (cnt > CNT_W'(1)) begin
                        rd_addr    = head_reg[lvl_reg];
                        state_next = S_UNL_TAKE;
                    end else begin
                        count_next[lvl_reg] = cnt - 1'b1;
                        state_next          = S_UNL_NEXT;
                    end
                end else if (cnt > CNT_W'(1)) begin
                    cur_next   = head_reg[lvl_reg];
                    pos_next   = CNT_W'(1);
                    rd_addr    = head_reg[lvl_reg];
                    state_next = S_UNL_RD;
                end else begin
                    state_next = S_UNL_NEXT;
                end
            end

            S_UNL_TAKE: begin
                head_next[lvl_reg]  = rd_data;
                count_next[lvl_reg] = cnt - 1'b1;
                state_next          = S_UNL_NEXT;
            end

            S_UNL_RD: begin
                if (rd_data == tgt) begin
                    if (pos_reg == (cnt - 1'b1)) begin
                        tail_next[lvl_reg]  = cur_reg;
                        count_next[lvl_reg] = cnt - 1'b1;
                        state_next          = S_UNL_NEXT;
                    end else begin
                        rd_addr    = rd_data;
                        state_next = S_UNL_FIX;
                    end
                end else begin
                    cur_next = rd_data;
                    if ((pos_reg + 1'b1) < cnt) begin
                        pos_next = pos_reg + 1'b1;
                        rd_addr  = rd_data;
                    end else begin
                        state_next = S_UNL_NEXT;
                    end
                end
            end

            S_UNL_FIX: begin
                mem_we              = 1'b1;
                mem_waddr           = cur_reg;
                mem_wdata           = rd_data;
                count_next[lvl_reg] = cnt - 1'b1;
                state_next          = S_UNL_NEXT;
            end

            // After the buddy, remove the block itself, then go up a level.
            S_UNL_NEXT: begin
                if (!tgt_sel_reg) begin
                    tgt_sel_next = 1'b1;
                    state_next   = S_UNL_START;
                end else begin
                    addr_next = merged;
                    lvl_next  = lvl_reg + 1'b1;
                    if (lvl_reg == LVL_W'(MAX_ORDER - 1)) begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_HOLD_INIT;
                    end
                end
            end

            S_DONE: begin
                if (rsp_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Append to a list tail; an append to a full list is dropped.
        if (app_en && (count_reg[app_ord] != CNT_W'(NUM_PAGES))) begin
            if (count_reg[app_ord] == '0) begin
                head_next[app_ord] = app_val;
            end else begin
                mem_we    = 1'b1;
                mem_waddr = tail_reg[app_ord];
                mem_wdata = app_val;
            end
            tail_next[app_ord]  = app_val;
            count_next[app_ord] = count_reg[app_ord] + 1'b1;
        end
    end

    // List registers and sequencer state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            for (int i = 0; i < NUM_ORDERS; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= (i == MAX_ORDER) ? CNT_W'(1) : '0;
            end
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current transaction.
    always_ff @(posedge aclk) begin
        lvl_reg     <= lvl_next;
        src_reg     <= src_next;
        addr_reg    <= addr_next;
        blk_reg     <= blk_next;
        cur_reg     <= cur_next;
        pos_reg     <= pos_next;
        tgt_sel_reg <= tgt_sel_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    assign req_ready            = (state_reg == S_IDLE);
    assign rsp_hs_out.valid     = (state_reg == S_DONE);
    assign rsp_hs_out.ready     = rsp_ready;
    assign rsp.status           = status_reg;
    assign rsp.granted_address  = granted_reg;

endmodule

FILE: hw/rtl/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: sequencer plus result register.
// Uses bpa_pkg and bpa_seq.
`timescale 1ns / 1ps

// Buddy allocator over 512 pages with orders 0 to 9, one free list per order,
// held as head, tail and count registers plus a 512-entry next-link RAM.
// Each transaction is handled alone by one sequencer that reaches the link
// RAM through a single read port with registered data, so time per
// transaction follows the list walks. An order out of range fails at once.
// An allocate scans the lists upward from its order, takes the head of the
// first nonempty one and splits it down level by level; a failed allocate
// ends after the scan. A free appends the block to its list and, below
// order 9, walks that list for the buddy at each level; each merge appends
// the merged block one order up and unlinks the buddy and the block. A
// stalled result receiver can hold the sequencer in its done state. The next
// transaction is taken while a finished result still waits in the output
// register.
module buddy_page_allocator_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bpa_pkg::bpa_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bpa_pkg::bpa_rsp_t m_data
);
    import bpa_pkg::*;

    bpa_hs_t  rsp_hs;
    bpa_rsp_t rsp;
    logic     rsp_ready;
    logic     out_valid_reg, out_valid_next;
    bpa_rsp_t out_data_reg;

    bpa_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req        (s_data),
        .rsp_hs_out (rsp_hs),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp)
    );

    // The output register takes a result when empty or being drained.
    assign rsp_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        if (rsp_hs.valid && rsp_hs.ready) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_hs.valid && rsp_hs.ready) begin
            out_data_reg <= rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
